FILE: rtl/cppt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the polygon point test.
`timescale 1ns / 1ps
`default_nettype none
package cppt_pkg;

   // Polygon storage size and coordinate width.
   localparam int MAX_CORNERS = 8;
   localparam int COORD_WIDTH = 16;

   // Widths that follow from the storage size and coordinate width.
   localparam int CORNER_W = $clog2(MAX_CORNERS);
   localparam int NCOUNT_W = $clog2(MAX_CORNERS + 1);
   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int PROD_W   = 2 * DIFF_W;

   // Field widths fixed by the interface.
   localparam int INDEX_W  = 3;
   localparam int VCOUNT_W = 4;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd4;

   // Request command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load_en;
      logic [CORNER_W-1:0] wr_addr;
      logic                query_start;
      logic                empty_query;
      logic                rd_en;
      logic                rd_first;
      logic [CORNER_W-1:0] rd_addr;
      logic                issue_wrap;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic done;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/cppt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cppt_ram #(
   parameter  int WIDTH  = 16,
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/cppt_ctrl.sv
// Controller: vertex count register, request acceptance and the edge walk sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cppt_ctrl
   import cppt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic                req_cmd,
   input  wire logic [INDEX_W-1:0]  req_vertex_index,
   input  wire logic                csr_we,
   input  wire logic [VCOUNT_W-1:0] csr_wdata,
   output      ctrl_cmd_type        cmd,
   input  wire dp_status_type       status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_WRAP = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [VCOUNT_W-1:0]   vcount_ff, vcount_in;
   logic [NCOUNT_W-1:0]   n_ff, n_in;
   logic [CORNER_W-1:0]   k_ff, k_in;
   logic [NCOUNT_W-1:0]   n_sat;
   logic                  last_read;

   // Vertex count in use, limited to the storage size.
   assign n_sat = (32'(vcount_ff) > MAX_CORNERS) ? NCOUNT_W'(MAX_CORNERS)
                                                 : NCOUNT_W'(vcount_ff);

   // The walk reads vertices 0 to n-1, then issues the closing edge.
   assign last_read = (NCOUNT_W'(k_ff) + NCOUNT_W'(1)) == n_ff;

   assign busy = (state_ff != ST_IDLE);

   // Configuration register write.
   always_comb begin
      vcount_in = vcount_ff;
      if (csr_we) begin
         vcount_in = csr_wdata;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      k_in            = k_ff;
      cmd             = '0;
      cmd.wr_addr     = CORNER_W'(req_vertex_index);
      cmd.rd_addr     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load_en = (32'(req_vertex_index) < MAX_CORNERS);
               end else begin
                  cmd.query_start = 1'b1;
                  n_in            = n_sat;
                  k_in            = '0;
                  if (n_sat == '0) begin
                     cmd.empty_query = 1'b1;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (k_ff == '0);
            if (last_read) begin
               state_in = ST_WRAP;
            end else begin
               k_in = k_ff + CORNER_W'(1);
            end
         end
         ST_WRAP: begin
            cmd.issue_wrap = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= VCOUNT_RESET;
         n_ff      <= '0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         n_ff      <= n_in;
         k_ff      <= k_in;
      end
   end

`ifndef SYNTHESIS
   // The walk never reads past the vertices in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (32'(k_ff) < 32'(n_ff)))
      else $error("vertex read beyond count in use");

   // A query result only completes while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == ST_WAIT))
      else $error("result completed outside of wait state");

   // A vertex load never shares a cycle with a walk read.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_en && cmd.rd_en))
      else $error("load and read in the same cycle");
`endif

endmodule
`default_nettype wire

FILE: rtl/cppt_datapath.sv
// Datapath: vertex stores, edge and point differences, cross products and sign check.
`timescale 1ns / 1ps
`default_nettype none
module cppt_datapath
   import cppt_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  wire ctrl_cmd_type                  cmd,
   output      dp_status_type                 status,
   output      logic                          rsp_valid,
   output      logic                          rsp_inside_res
);

   logic [COORD_WIDTH-1:0] ram_x, ram_y;

   logic signed [COORD_WIDTH-1:0] px_ff, py_ff;
   logic signed [COORD_WIDTH-1:0] v0x_ff, v0y_ff;
   logic signed [COORD_WIDTH-1:0] prevx_ff, prevy_ff;
   logic signed [COORD_WIDTH-1:0] curx, cury;

   logic iss_valid_ff, iss_first_ff, iss_wrap_ff;

   logic                     d_valid_ff, d_last_ff;
   logic signed [DIFF_W-1:0] ex_ff, ey_ff, dx_ff, dy_ff;
   logic signed [DIFF_W-1:0] ex_in, ey_in, dx_in, dy_in;

   logic                     p_valid_ff, p_last_ff;
   logic signed [PROD_W-1:0] pa_ff, pb_ff;
   logic signed [PROD_W-1:0] pa_in, pb_in;

   logic neg_ff, neg_now, less;
   logic rsp_valid_ff, rsp_inside_ff;

   // Vertex stores, one per coordinate.
   cppt_ram #(
      .WIDTH (COORD_WIDTH),
      .DEPTH (MAX_CORNERS)
   ) u_ram_x (
      .clock   (clock),
      .wr_en   (cmd.load_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (req_coord_x),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_x)
   );

   cppt_ram #(
      .WIDTH (COORD_WIDTH),
      .DEPTH (MAX_CORNERS)
   ) u_ram_y (
      .clock   (clock),
      .wr_en   (cmd.load_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (req_coord_y),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_y)
   );

   // Query point capture.
   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
   end

   // Issue tags that line up with the registered read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
      end else begin
         iss_valid_ff <= cmd.rd_en | cmd.issue_wrap;
      end
      iss_first_ff <= cmd.rd_first;
      iss_wrap_ff  <= cmd.issue_wrap;
   end

   // The closing edge ends at vertex 0; every other edge ends at the vertex just read.
   assign curx = iss_wrap_ff ? v0x_ff : $signed(ram_x);
   assign cury = iss_wrap_ff ? v0y_ff : $signed(ram_y);

   assign ex_in = DIFF_W'(curx)  - DIFF_W'(prevx_ff);
   assign ey_in = DIFF_W'(cury)  - DIFF_W'(prevy_ff);
   assign dx_in = DIFF_W'(px_ff) - DIFF_W'(prevx_ff);
   assign dy_in = DIFF_W'(py_ff) - DIFF_W'(prevy_ff);

   // Edge start tracking and difference stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= iss_valid_ff & ~iss_first_ff;
      end
      if (iss_valid_ff) begin
         prevx_ff <= curx;
         prevy_ff <= cury;
         if (iss_first_ff) begin
            v0x_ff <= curx;
            v0y_ff <= cury;
         end
      end
      d_last_ff <= iss_wrap_ff;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
   end

   // Cross product terms.
   assign pa_in = ex_ff * dy_ff;
   assign pb_in = ey_ff * dx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= d_valid_ff;
      end
      p_last_ff <= d_last_ff;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
   end

   // A negative cross product means the point lies on the outer side of that edge.
   assign less    = p_valid_ff && (pa_ff < pb_ff);
   assign neg_now = neg_ff | less;

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.query_start) begin
            neg_ff <= 1'b0;
         end else begin
            neg_ff <= neg_now;
         end
         rsp_valid_ff <= cmd.empty_query | (p_valid_ff & p_last_ff);
      end
      if (cmd.empty_query) begin
         rsp_inside_ff <= 1'b1;
      end else if (p_valid_ff && p_last_ff) begin
         rsp_inside_ff <= ~neg_now;
      end
   end

   assign status.done    = p_valid_ff & p_last_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

`ifndef SYNTHESIS
   // Every issued edge passes through the difference stage and reaches the product stage.
   assert property (@(posedge clock) disable iff (reset)
      (iss_valid_ff && !iss_first_ff) |=> ##1 p_valid_ff)
      else $error("edge lost between issue and product stage");

   // The closing edge is the one that raises the result beat.
   assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && p_last_ff) |=> rsp_valid_ff)
      else $error("closing edge did not produce a result beat");

   // A result from an empty polygon always reports inside.
   assert property (@(posedge clock) disable iff (reset)
      cmd.empty_query |=> (rsp_valid_ff && rsp_inside_ff))
      else $error("empty polygon result not inside");
`endif

endmodule
`default_nettype wire

FILE: rtl/convex_polygon_point_test_unit.sv
// Top level of the point in convex polygon test: controller plus datapath.
// A vertex load leaves busy low, so a beat may follow every cycle.
// A query with n > 0 vertices in use holds busy through the n vertex reads, the closing
// edge, then the difference and product stages; its result comes in the same cycle that busy falls.
// A query with no vertex in use answers inside the next cycle; the receiver cannot stall.
// Synchronous reset returns the controller to idle and vertex_count to 4; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module convex_polygon_point_test_unit
   import cppt_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic                          req_cmd,
   input  wire logic [INDEX_W-1:0]            req_vertex_index,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_y,
   output      logic                          rsp_valid,
   output      logic                          rsp_inside_res,
   input  wire logic                          csr_we,
   input  wire logic [VCOUNT_W-1:0]           csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer and configuration register.
   cppt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_vertex_index (req_vertex_index),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status)
   );

   // Vertex stores and edge arithmetic.
   cppt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule
`default_nettype wire
